>>> rtl/lcts_pkg.sv
// Package: shared constants, payload and configuration types for the LBA to CHS track splitter.
package lcts_pkg;

    localparam int MAX_CHUNK_SECTORS   = 16;
    localparam int MAX_REQUEST_SECTORS = 64;

    localparam int COUNT_W  = 7;
    localparam int SPT_W    = 8;
    localparam int HEADS_W  = 9;
    localparam int SPCYL_W  = SPT_W + HEADS_W;
    localparam int LBA_W    = 32;
    localparam int DIV_STEPS = LBA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SPT_W-1:0]   SPT_RESET   = 8'd63;
    localparam logic [HEADS_W-1:0] HEADS_RESET = 9'd16;

    typedef enum logic
    {
        REG_SECTORS_PER_TRACK = 1'b0,
        REG_HEAD_COUNT        = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [7:0]         drive;
        logic [LBA_W-1:0]   start_sector;
        logic [COUNT_W-1:0] sector_count;
    } req_item_t;

    typedef struct packed
    {
        logic [7:0]         drive_out;
        logic [LBA_W-1:0]   cylinder;
        logic [7:0]         head;
        logic [7:0]         track_sector;
        logic [COUNT_W-1:0] run_length;
        logic               geometry_error;
        logic               last;
    } cmd_item_t;

    typedef struct packed
    {
        logic [SPT_W-1:0]   sectors_per_track;
        logic [HEADS_W-1:0] head_count;
    } geom_cfg_t;

    typedef struct packed
    {
        logic               start;
        logic [LBA_W-1:0]   dividend;
        logic [SPCYL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed
    {
        logic               done;
        logic [LBA_W-1:0]   quotient;
        logic [SPCYL_W-1:0] remainder;
    } div_rsp_t;

endpackage

>>> rtl/lba_to_chs_track_splitter.sv
// Top level: request sequencer splitting a linear read into track-bounded CHS commands.
//
//  Channel | Direction | Handshake                   | Payload
//  --------+-----------+-----------------------------+-----------------------------
//  req     | in        | req_valid / req_ready       | req_item_t (drive, LBA, count)
//  cmd     | out       | cmd_valid / cmd_ready       | cmd_item_t (one per command)
//  apb     | in/out    | psel, penable, pwrite, ...  | geometry registers at 0x0, 0x4
//
// One request is taken at a time; req_ready is high only while the sequencer is idle.
// Each command takes two passes through the shared 32-step divider (cylinder, then
// head/sector) and is then loaded into the output register; a full 64-sector request
// can split into as many as 64 commands.
// A geometry error or an empty request is settled in the check state without the divider.
// The command register holds its transfer until cmd_ready; the sequencer waits meanwhile.
// Reset clears the sequencer and loads 63 sectors per track and 16 heads.
module lba_to_chs_track_splitter import lcts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_item_t             req,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output cmd_item_t             cmd,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [4:0]
    {
        ST_IDLE     = 5'b00001,
        ST_CHECK    = 5'b00010,
        ST_DIV_CYL  = 5'b00100,
        ST_DIV_HEAD = 5'b01000,
        ST_OUT      = 5'b10000
    } state_t;

    localparam logic [COUNT_W-1:0] REQ_MAX = COUNT_W'(MAX_REQUEST_SECTORS);
    localparam logic [SPT_W-1:0]   CHUNK   = SPT_W'(MAX_CHUNK_SECTORS);

    geom_cfg_t geom;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    state_t             state_reg;
    state_t             state_next;
    logic               cmd_valid_reg;
    logic               cmd_valid_next;
    cmd_item_t          cmd_reg;
    cmd_item_t          cmd_next;
    logic [7:0]         drive_reg;
    logic [7:0]         drive_next;
    logic [LBA_W-1:0]   sector_reg;
    logic [LBA_W-1:0]   sector_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [SPCYL_W-1:0] spcyl_reg;
    logic [SPCYL_W-1:0] spcyl_next;
    logic [LBA_W-1:0]   cyl_reg;
    logic [LBA_W-1:0]   cyl_next;

    logic               req_xfer;
    logic               cmd_xfer;
    logic [SPT_W-1:0]   ts;
    logic [SPT_W-1:0]   left_on_track;
    logic [SPT_W-1:0]   run_w;
    logic [COUNT_W-1:0] run;
    logic [COUNT_W-1:0] count_after;

    lcts_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    lcts_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign req_xfer  = req_valid & req_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;
    assign cmd_xfer  = cmd_valid_reg & cmd_ready;

    // Command length: smallest of track remainder, request remainder and chunk cap
    assign ts            = div_rsp.remainder[SPT_W-1:0];
    always_comb
    begin
        left_on_track = geom.sectors_per_track - ts;
        run_w         = left_on_track;
        if ({1'b0, count_reg} < run_w)
        begin
            run_w = {1'b0, count_reg};
        end
        if (CHUNK < run_w)
        begin
            run_w = CHUNK;
        end
    end
    assign run         = run_w[COUNT_W-1:0];
    assign count_after = count_reg - run;

    always_comb
    begin
        state_next     = state_reg;
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        drive_next     = drive_reg;
        sector_next    = sector_reg;
        count_next     = count_reg;
        spcyl_next     = spcyl_reg;
        cyl_next       = cyl_reg;

        div_req.start    = 1'b0;
        div_req.dividend = sector_reg;
        div_req.divisor  = spcyl_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    // Latch the request and saturate oversized counts
                    drive_next  = req.drive;
                    sector_next = req.start_sector;
                    count_next  = (req.sector_count > REQ_MAX) ? REQ_MAX : req.sector_count;
                    spcyl_next  = SPCYL_W'(geom.sectors_per_track) *
                                  SPCYL_W'(geom.head_count);
                    state_next  = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if ((geom.sectors_per_track == '0) || (spcyl_reg == '0))
                begin
                    // Bad geometry: one flagged last command carrying the drive, all other fields zero
                    cmd_next.drive_out      = drive_reg;
                    cmd_next.cylinder       = '0;
                    cmd_next.head           = '0;
                    cmd_next.track_sector   = '0;
                    cmd_next.run_length     = '0;
                    cmd_next.geometry_error = 1'b1;
                    cmd_next.last           = 1'b1;
                    cmd_valid_next          = 1'b1;
                    state_next              = ST_OUT;
                end
                else if (count_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_CYL;
                end
            end

            ST_DIV_CYL:
            begin
                // Keep the cylinder and feed the remainder straight into the head split
                div_req.dividend = LBA_W'(div_rsp.remainder);
                div_req.divisor  = SPCYL_W'(geom.sectors_per_track);
                if (div_rsp.done)
                begin
                    cyl_next      = div_rsp.quotient;
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_HEAD;
                end
            end

            ST_DIV_HEAD:
            begin
                if (div_rsp.done)
                begin
                    cmd_next.drive_out      = drive_reg;
                    cmd_next.cylinder       = cyl_reg;
                    cmd_next.head           = div_rsp.quotient[7:0];
                    cmd_next.track_sector   = ts;
                    cmd_next.run_length     = run;
                    cmd_next.geometry_error = 1'b0;
                    cmd_next.last           = (count_after == '0);
                    cmd_valid_next          = 1'b1;
                    count_next              = count_after;
                    sector_next             = sector_reg + LBA_W'(run);
                    state_next              = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (cmd_xfer)
                begin
                    cmd_valid_next = 1'b0;
                    if (cmd_reg.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Advance to the next track-bounded piece
                        div_req.start = 1'b1;
                        state_next    = ST_DIV_CYL;
                    end
                end
            end

            default:
            begin
                state_next     = ST_IDLE;
                cmd_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        drive_reg  <= drive_next;
        sector_reg <= sector_next;
        count_reg  <= count_next;
        spcyl_reg  <= spcyl_next;
        cyl_reg    <= cyl_next;
    end

endmodule

>>> rtl/lcts_regs.sv
// Geometry register file behind the APB-style configuration port.
module lcts_regs import lcts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output geom_cfg_t             geom
);

    logic [SPT_W-1:0]   spt_reg;
    logic [SPT_W-1:0]   spt_next;
    logic [HEADS_W-1:0] heads_reg;
    logic [HEADS_W-1:0] heads_next;
    logic               wr_en;
    reg_index_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_index_t'(paddr[2]);

    always_comb
    begin
        spt_next   = spt_reg;
        heads_next = heads_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SECTORS_PER_TRACK: spt_next   = pwdata[SPT_W-1:0];
                REG_HEAD_COUNT:        heads_next = pwdata[HEADS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg   <= SPT_RESET;
            heads_reg <= HEADS_RESET;
        end
        else
        begin
            spt_reg   <= spt_next;
            heads_reg <= heads_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_SECTORS_PER_TRACK: prdata = APB_DATA_W'(spt_reg);
            REG_HEAD_COUNT:        prdata = APB_DATA_W'(heads_reg);
            default:               prdata = '0;
        endcase
    end

    assign geom.sectors_per_track = spt_reg;
    assign geom.head_count        = heads_reg;

endmodule

>>> rtl/lcts_divider.sv
// Shared restoring divider: one quotient bit per cycle while busy.
module lcts_divider import lcts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [LBA_W-1:0]     quo_reg;
    logic [LBA_W-1:0]     quo_next;
    logic [SPCYL_W-1:0]   rem_reg;
    logic [SPCYL_W-1:0]   rem_next;
    logic [SPCYL_W-1:0]   dvs_reg;
    logic [SPCYL_W-1:0]   dvs_next;
    logic [SPCYL_W:0]     partial;
    logic                 fits;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign partial = {rem_reg, quo_reg[LBA_W-1]};
    assign fits    = (partial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[LBA_W-2:0], fits};
            rem_next = fits ? SPCYL_W'(partial - {1'b0, dvs_reg}) : partial[SPCYL_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
